@@ sv/ssba_pkg.sv @@
`default_nettype none
package ssba_pkg;

  // bitmap geometry
  localparam int WORD_W       = 64;
  localparam int BIT_W        = 6;
  localparam int EXT_W        = 2 * WORD_W;
  localparam int CNT_W        = 14;
  localparam int SECT_W       = 13;
  localparam int STAT_W       = 2;
  localparam int DEF_MAX_SECT = 8192;
  localparam int DEF_RUN_LEN  = 8;
  localparam logic [CNT_W-1:0] CNT_RESET = 14'd8192;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AL_SCAN,
    ST_FR_RD0,
    ST_FR_RD1,
    ST_FR_CHK,
    ST_WR_LO,
    ST_WR_HI,
    ST_RESP
  } state_t;

  // outcome of searching one map word for the end of a free run
  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  pos;
    logic [EXT_W-1:0]  set_mask;
  } scan_res_t;

endpackage
`default_nettype wire

@@ sv/ssba_mem.sv @@
`default_nettype none
module ssba_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/ssba_scan.sv @@
`default_nettype none
module ssba_scan #(
  parameter int RUN_LENGTH = 8
) (
  input  wire logic [ssba_pkg::WORD_W-1:0] cur_used,
  input  wire logic [ssba_pkg::WORD_W-1:0] cur_valid,
  input  wire logic [ssba_pkg::WORD_W-1:0] prev_free,
  output logic      [ssba_pkg::WORD_W-1:0] cur_free,
  output ssba_pkg::scan_res_t              res
);
  import ssba_pkg::*;

  localparam logic [EXT_W-1:0] ONES_R = (EXT_W'(1) << RUN_LENGTH) - EXT_W'(1);

  logic [EXT_W-1:0]  ext;
  logic [EXT_W-1:0]  runs;
  logic [WORD_W-1:0] hit;
  logic [WORD_W-1:0] hit_oh;
  logic [BIT_W-1:0]  pos;
  logic [BIT_W:0]    sh;

  // free bits of the previous and current word side by side
  assign cur_free = ~cur_used & cur_valid;
  assign ext      = {cur_free, prev_free};

  // bit j set when the RUN_LENGTH bits ending at j are all free
  always_comb begin
    runs = ext;
    for (int k = 1; k < RUN_LENGTH; k++) begin
      runs = runs & (ext << k);
    end
  end

  // lowest run end inside the current word
  assign hit    = runs[EXT_W-1:WORD_W];
  assign hit_oh = hit & (~hit + WORD_W'(1));

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (hit_oh[i]) begin
        pos = pos | BIT_W'(i);
      end
    end
  end

  // mask of the run in the two-word window
  assign sh = (BIT_W+1)'(WORD_W + 32'(pos) + 1 - RUN_LENGTH);

  assign res.found    = |hit;
  assign res.pos      = pos;
  assign res.set_mask = ONES_R << sh;

endmodule
`default_nettype wire

@@ sv/swap_slot_bitmap_allocator.sv @@
`default_nettype none
// First-fit allocator of contiguous swap sector runs over a used-sector bitmap.
// Input channel: in_valid/in_stall with in_opcode (0 allocate, 1 free) and
// in_start_sector (first sector to free). Result channel: out_valid/out_stall
// with out_result_sector and out_status (0 ok, 1 full, 2 bad free range).
// cfg_wr_en/cfg_wr_data set the managed sector count; the user must write it only
// while the block is idle, which the block itself leaves unenforced. The bitmap
// sits in a 64-bit wide synchronous RAM, one word read per cycle. Allocate: the
// scan reads words from sector 0 upward, one word per cycle, until a run ends or
// the last word is examined, at most ceil(count/64) words (128 at the default
// size); a found run is written into the map before the result is sent.
// Free: read two words, check, write back, then respond; a range that passes the
// count is refused without reading, one with a free sector after the check.
// One request is handled at a time; in_stall is low only when the block is
// idle. The result waits in an output register, so a stalled receiver holds
// the block only when a second result is ready before the first is taken.
// Reset: synchronous, active low; afterwards a clearing pass writes every RAM
// word to zero with in_stall high. The sector count returns to 8192.
module swap_slot_bitmap_allocator #(
  parameter int MAX_SECTORS = ssba_pkg::DEF_MAX_SECT,
  parameter int RUN_LENGTH  = ssba_pkg::DEF_RUN_LEN
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_opcode,
  input  wire logic [ssba_pkg::SECT_W-1:0] in_start_sector,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [ssba_pkg::SECT_W-1:0] out_result_sector,
  output logic      [ssba_pkg::STAT_W-1:0] out_status,
  input  wire logic                        cfg_wr_en,
  input  wire logic [ssba_pkg::CNT_W-1:0]  cfg_wr_data
);
  import ssba_pkg::*;

  localparam int WORDS = (MAX_SECTORS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     ev_w_r, ev_w_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]     fa_r, fa_nxt;
  logic [BIT_W-1:0]  fbit_r, fbit_nxt;
  logic [WORD_W-1:0] prev_free_r, prev_free_nxt;
  logic [WORD_W-1:0] prev_used_r, prev_used_nxt;
  logic [AW-1:0]     lo_addr_r, lo_addr_nxt;
  logic [AW-1:0]     hi_addr_r, hi_addr_nxt;
  logic [WORD_W-1:0] lo_data_r, lo_data_nxt;
  logic [WORD_W-1:0] hi_data_r, hi_data_nxt;
  logic              wr_lo_r, wr_lo_nxt;
  logic              wr_hi_r, wr_hi_nxt;
  logic [SECT_W-1:0] res_sect_r, res_sect_nxt;
  status_t           res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SECT_W-1:0] out_sect_r, out_sect_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_m1;
  logic              last_word;
  logic [WORD_W-1:0] word_valid;
  logic [WORD_W-1:0] cur_free;
  scan_res_t         scan;
  logic [EXT_W-1:0]  free_mask;
  logic              free_ok;
  logic              in_xfer;

  // effective sector count
  assign n_eff = (32'(count_r) > MAX_SECTORS) ? CNT_W'(MAX_SECTORS) : count_r;
  assign n_m1  = n_eff - CNT_W'(1);

  // sectors of the word under evaluation that lie below the count
  assign last_word  = (32'(ev_w_r) == 32'(n_m1[CNT_W-1:BIT_W]));
  assign word_valid = (last_word && (n_eff[BIT_W-1:0] != '0)) ?
                      ((WORD_W'(1) << n_eff[BIT_W-1:0]) - WORD_W'(1)) : '1;

  // free range in the two words starting at the first word of the run
  assign free_mask = ((EXT_W'(1) << RUN_LENGTH) - EXT_W'(1)) << fbit_r;
  assign free_ok   = (({mem_rdata, lo_data_r} & free_mask) == free_mask);

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  ssba_mem #(
    .DEPTH (WORDS),
    .AW    (AW),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ssba_scan #(
    .RUN_LENGTH (RUN_LENGTH)
  ) u_scan (
    .cur_used  (mem_rdata),
    .cur_valid (word_valid),
    .prev_free (prev_free_r),
    .cur_free  (cur_free),
    .res       (scan)
  );

  // sector count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_RESET;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      wr_lo_r     <= 1'b0;
      wr_hi_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      wr_lo_r     <= wr_lo_nxt;
      wr_hi_r     <= wr_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ev_w_r      <= ev_w_nxt;
    fa_r        <= fa_nxt;
    fbit_r      <= fbit_nxt;
    prev_free_r <= prev_free_nxt;
    prev_used_r <= prev_used_nxt;
    lo_addr_r   <= lo_addr_nxt;
    hi_addr_r   <= hi_addr_nxt;
    lo_data_r   <= lo_data_nxt;
    hi_data_r   <= hi_data_nxt;
    res_sect_r  <= res_sect_nxt;
    res_stat_r  <= res_stat_nxt;
    out_sect_r  <= out_sect_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // sequencer: next state, memory ports, result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ev_w_nxt      = ev_w_r;
    rd_vld_nxt    = 1'b0;
    fa_nxt        = fa_r;
    fbit_nxt      = fbit_r;
    prev_free_nxt = prev_free_r;
    prev_used_nxt = prev_used_r;
    lo_addr_nxt   = lo_addr_r;
    hi_addr_nxt   = hi_addr_r;
    lo_data_nxt   = lo_data_r;
    hi_data_nxt   = hi_data_r;
    wr_lo_nxt     = wr_lo_r;
    wr_hi_nxt     = wr_hi_r;
    res_sect_nxt  = res_sect_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sect_nxt  = out_sect_r;
    out_stat_nxt  = out_stat_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = '0;
    mem_raddr     = cnt_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          res_sect_nxt  = '0;
          res_stat_nxt  = STAT_OK;
          cnt_nxt       = '0;
          prev_free_nxt = '0;
          prev_used_nxt = '0;
          fa_nxt        = AW'(in_start_sector[SECT_W-1:BIT_W]);
          fbit_nxt      = in_start_sector[BIT_W-1:0];
          if (in_opcode == OP_ALLOC) begin
            if (n_eff == '0) begin
              res_stat_nxt = STAT_FULL;
              state_nxt    = ST_RESP;
            end else begin
              state_nxt = ST_AL_SCAN;
            end
          end else if (32'(in_start_sector) + RUN_LENGTH > 32'(n_eff)) begin
            res_stat_nxt = STAT_BAD_FREE;
            state_nxt    = ST_RESP;
          end else begin
            state_nxt = ST_FR_RD0;
          end
        end
      end

      ST_AL_SCAN: begin
        // issue one read per cycle, evaluate the word that returns
        mem_raddr  = cnt_r;
        cnt_nxt    = cnt_r + AW'(1);
        ev_w_nxt   = cnt_r;
        rd_vld_nxt = 1'b1;
        if (rd_vld_r) begin
          if (scan.found) begin
            hi_addr_nxt  = ev_w_r;
            hi_data_nxt  = mem_rdata | scan.set_mask[EXT_W-1:WORD_W];
            lo_addr_nxt  = ev_w_r - AW'(1);
            lo_data_nxt  = prev_used_r | scan.set_mask[WORD_W-1:0];
            wr_hi_nxt    = 1'b1;
            wr_lo_nxt    = |scan.set_mask[WORD_W-1:0];
            res_sect_nxt = SECT_W'((32'(ev_w_r) << BIT_W) + 32'(scan.pos) + 1
                                   - RUN_LENGTH);
            rd_vld_nxt   = 1'b0;
            state_nxt    = ST_WR_LO;
          end else if (last_word) begin
            res_stat_nxt = STAT_FULL;
            rd_vld_nxt   = 1'b0;
            state_nxt    = ST_RESP;
          end else begin
            prev_free_nxt = cur_free;
            prev_used_nxt = mem_rdata;
          end
        end
      end

      ST_FR_RD0: begin
        mem_raddr = fa_r;
        state_nxt = ST_FR_RD1;
      end

      ST_FR_RD1: begin
        mem_raddr   = fa_r + AW'(1);
        lo_data_nxt = mem_rdata;
        state_nxt   = ST_FR_CHK;
      end

      ST_FR_CHK: begin
        lo_addr_nxt = fa_r;
        hi_addr_nxt = fa_r + AW'(1);
        if (free_ok) begin
          lo_data_nxt = lo_data_r & ~free_mask[WORD_W-1:0];
          hi_data_nxt = mem_rdata & ~free_mask[EXT_W-1:WORD_W];
          wr_lo_nxt   = 1'b1;
          wr_hi_nxt   = |free_mask[EXT_W-1:WORD_W];
          state_nxt   = ST_WR_LO;
        end else begin
          res_stat_nxt = STAT_BAD_FREE;
          state_nxt    = ST_RESP;
        end
      end

      ST_WR_LO: begin
        mem_we    = wr_lo_r;
        mem_waddr = lo_addr_r;
        mem_wdata = lo_data_r;
        state_nxt = ST_WR_HI;
      end

      ST_WR_HI: begin
        mem_we    = wr_hi_r;
        mem_waddr = hi_addr_r;
        mem_wdata = hi_data_r;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sect_nxt  = res_sect_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_result_sector = out_sect_r;
  assign out_status        = out_stat_r;

  // a new result only comes out of the response state
  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result appeared outside the response state");

  // the scan never overlaps a bitmap write
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AL_SCAN || state_r == ST_FR_RD0 || state_r == ST_FR_RD1)
    |-> !mem_we)
    else $error("bitmap written during a read phase");

  // failed requests report sector zero
  a_fail_sector_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r != STAT_OK |-> out_sect_r == '0)
    else $error("failed request carries a sector");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_stat_r == STAT_OK || out_stat_r == STAT_FULL ||
                     out_stat_r == STAT_BAD_FREE))
    else $error("undefined status code");

endmodule
`default_nettype wire
